/* rtl/ordered_array_list_macros.svh */
// ----------------------------------------------------------------------------
// Ordered array list assertion macros
// Short forms for the concurrent assertions of the block's checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array list package
// Command codes, controller states and the control and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package oal_pkg;

    // Default number of entries the list can hold.
    localparam int DEF_CAPACITY = 64;

    // Width of the command code and of one entry field.
    localparam int CMD_W   = 3;
    localparam int FIELD_W = 32;

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4
    } cmd_t;

    // Address sources for the entry memory ports.
    typedef enum logic [2:0] {
        ADDR_POS,
        ADDR_CNT,
        ADDR_PTR,
        ADDR_PTR_DN,
        ADDR_PTR_UP
    } addr_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UP_CHECK,
        ST_UP_WRITE,
        ST_DN_CHECK,
        ST_DN_WRITE,
        ST_CAPTURE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_in;
        logic      res_init;
        logic      res_capture;
        logic      mem_we;
        logic      wr_from_rd;
        addr_sel_t waddr_sel;
        logic      mem_re;
        addr_sel_t raddr_sel;
        logic      ptr_load_cnt;
        logic      ptr_load_pos;
        logic      ptr_inc;
        logic      ptr_dec;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      out_load;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             legal;
        logic             ptr_at_pos;
        logic             ptr_at_end;
        logic             out_free;
    } dp_status_t;

endpackage

/* rtl/oal_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered array list controller
// Sequences each command: range check, memory accesses, entry shifting and
// the hand-off of the result word to the output register.
// ----------------------------------------------------------------------------
module oal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  oal_pkg::dp_status_t status,
    output oal_pkg::ctl_cmd_t  ctl
);
    import oal_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.waddr_sel = ADDR_POS;
        ctl.raddr_sel = ADDR_POS;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.res_init = 1'b1;
                state_next   = ST_FINISH;
                if (status.legal)
                begin
                    case (status.cmd)
                        CMD_APPEND:
                        begin
                            ctl.mem_we    = 1'b1;
                            ctl.waddr_sel = ADDR_CNT;
                            ctl.cnt_inc   = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            ctl.ptr_load_cnt = 1'b1;
                            state_next       = ST_UP_CHECK;
                        end
                        CMD_DELETE:
                        begin
                            ctl.mem_re       = 1'b1;
                            ctl.raddr_sel    = ADDR_POS;
                            ctl.ptr_load_pos = 1'b1;
                            state_next       = ST_CAPTURE;
                        end
                        CMD_READ:
                        begin
                            ctl.mem_re    = 1'b1;
                            ctl.raddr_sel = ADDR_POS;
                            state_next    = ST_CAPTURE;
                        end
                        CMD_WRITE:
                        begin
                            ctl.mem_we    = 1'b1;
                            ctl.waddr_sel = ADDR_POS;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_UP_CHECK:
            begin
                // Once the gap reaches the position, the new entry drops in.
                if (status.ptr_at_pos)
                begin
                    ctl.mem_we    = 1'b1;
                    ctl.waddr_sel = ADDR_POS;
                    ctl.cnt_inc   = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ctl.mem_re    = 1'b1;
                    ctl.raddr_sel = ADDR_PTR_DN;
                    state_next    = ST_UP_WRITE;
                end
            end
            ST_UP_WRITE:
            begin
                ctl.mem_we     = 1'b1;
                ctl.wr_from_rd = 1'b1;
                ctl.waddr_sel  = ADDR_PTR;
                ctl.ptr_dec    = 1'b1;
                state_next     = ST_UP_CHECK;
            end
            ST_CAPTURE:
            begin
                ctl.res_capture = 1'b1;
                if (status.cmd == CMD_DELETE)
                begin
                    state_next = ST_DN_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DN_CHECK:
            begin
                // The last entry has moved down once the pointer reaches the end.
                if (status.ptr_at_end)
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    ctl.mem_re    = 1'b1;
                    ctl.raddr_sel = ADDR_PTR_UP;
                    state_next    = ST_DN_WRITE;
                end
            end
            ST_DN_WRITE:
            begin
                ctl.mem_we     = 1'b1;
                ctl.wr_from_rd = 1'b1;
                ctl.waddr_sel  = ADDR_PTR;
                ctl.ptr_inc    = 1'b1;
                state_next     = ST_DN_CHECK;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/oal_datapath.sv */
// ----------------------------------------------------------------------------
// Ordered array list datapath
// Command registers, entry memory, fill count, shift pointer, result hold
// and the output register.
// ----------------------------------------------------------------------------
module oal_datapath #(
    parameter int CAPACITY = oal_pkg::DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [oal_pkg::CMD_W-1:0]     in_cmd,
    input  logic [CNT_W-1:0]              in_position,
    input  logic [oal_pkg::FIELD_W-1:0]   in_number,
    input  logic [oal_pkg::FIELD_W-1:0]   in_name_ref,
    input  oal_pkg::ctl_cmd_t             ctl,
    output oal_pkg::dp_status_t           status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_ok,
    output logic [oal_pkg::FIELD_W-1:0]   out_number,
    output logic [oal_pkg::FIELD_W-1:0]   out_name_ref,
    output logic [CNT_W-1:0]              out_fill
);
    import oal_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENT_W = 2 * FIELD_W;

    // Latched command word.
    logic [CMD_W-1:0]   cmd_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [FIELD_W-1:0] num_reg;
    logic [FIELD_W-1:0] name_reg;

    // Control state.
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   ptr_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Result hold and output register.
    logic               res_ok_reg;
    logic [FIELD_W-1:0] res_num_reg;
    logic [FIELD_W-1:0] res_name_reg;
    logic               out_ok_reg;
    logic [FIELD_W-1:0] out_num_reg;
    logic [FIELD_W-1:0] out_name_reg;
    logic [CNT_W-1:0]   out_fill_reg;

    // Entry memory: name handle in the upper half, number in the lower half.
    logic [ENT_W-1:0]   mem [CAPACITY];
    logic [ENT_W-1:0]   rd_data_reg;
    logic [ENT_W-1:0]   wr_data;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   raddr;

    logic [CNT_W-1:0]   ptr_dn;
    logic [CNT_W-1:0]   ptr_up;
    logic               legal;

    assign ptr_dn = ptr_reg - CNT_W'(1);
    assign ptr_up = ptr_reg + CNT_W'(1);

    // Range and capacity check of the latched command.
    always_comb
    begin
        case (cmd_reg)
            CMD_APPEND:
            begin
                legal = (count_reg < CNT_W'(CAPACITY));
            end
            CMD_INSERT:
            begin
                legal = (count_reg < CNT_W'(CAPACITY)) && (pos_reg <= count_reg);
            end
            CMD_DELETE, CMD_READ, CMD_WRITE:
            begin
                legal = (pos_reg < count_reg);
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    assign status.cmd        = cmd_reg;
    assign status.legal      = legal;
    assign status.ptr_at_pos = (ptr_reg == pos_reg);
    assign status.ptr_at_end = (ptr_up >= count_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Memory address selection.
    always_comb
    begin
        case (ctl.waddr_sel)
            ADDR_POS: waddr = pos_reg[IDX_W-1:0];
            ADDR_CNT: waddr = count_reg[IDX_W-1:0];
            ADDR_PTR: waddr = ptr_reg[IDX_W-1:0];
            default:  waddr = pos_reg[IDX_W-1:0];
        endcase
        case (ctl.raddr_sel)
            ADDR_POS:    raddr = pos_reg[IDX_W-1:0];
            ADDR_PTR_DN: raddr = ptr_dn[IDX_W-1:0];
            ADDR_PTR_UP: raddr = ptr_up[IDX_W-1:0];
            default:     raddr = pos_reg[IDX_W-1:0];
        endcase
    end

    assign wr_data = ctl.wr_from_rd ? rd_data_reg : {name_reg, num_reg};

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
        begin
            mem[waddr] <= wr_data;
        end
        if (ctl.mem_re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Next values of the fill count, shift pointer and output valid.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        ptr_next = ptr_reg;
        if (ctl.ptr_load_cnt)
        begin
            ptr_next = count_reg;
        end
        else if (ctl.ptr_load_pos)
        begin
            ptr_next = pos_reg;
        end
        else if (ctl.ptr_inc)
        begin
            ptr_next = ptr_up;
        end
        else if (ctl.ptr_dec)
        begin
            ptr_next = ptr_dn;
        end

        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: command word, pointer, result hold and output word.
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.load_in)
        begin
            cmd_reg  <= in_cmd;
            pos_reg  <= in_position;
            num_reg  <= in_number;
            name_reg <= in_name_ref;
        end
        if (ctl.res_init)
        begin
            res_ok_reg   <= legal;
            res_num_reg  <= '0;
            res_name_reg <= '0;
        end
        else if (ctl.res_capture)
        begin
            res_num_reg  <= rd_data_reg[FIELD_W-1:0];
            res_name_reg <= rd_data_reg[ENT_W-1:FIELD_W];
        end
        if (ctl.out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_num_reg  <= res_num_reg;
            out_name_reg <= res_name_reg;
            out_fill_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_ok       = out_ok_reg;
    assign out_number   = out_num_reg;
    assign out_name_ref = out_name_reg;
    assign out_fill     = out_fill_reg;

endmodule

/* rtl/ordered_array_list.sv */
// ----------------------------------------------------------------------------
// Ordered array list
// Fixed-capacity ordered list of number and name-handle entries with append,
// insert, delete, read and write commands, one result word per command.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and answers each with exactly
// one result word. Append, write and any rejected command pass from the
// execute state straight to the finish state; read passes through a capture
// state on the way. Insert first shifts every entry at or above the position
// up by one place, and delete captures the entry and then shifts every entry
// above the position down by one place. The result word is loaded into the
// output register as the controller leaves the finish state for idle. The
// longest command is a delete at the front of a full list (64 entries at the
// default capacity). The controller moves each shifted entry through the
// entry memory in two steps: a registered read and then a write. While an
// older result word still waits downstream, the next one is held back in the finish state.
// A new command is taken as soon as the previous one has been handed to the
// output register, even if that result word has not yet been taken
// downstream. The entry memory is not cleared after reset; only entries
// below the fill count are ever read.
module ordered_array_list #(
    parameter int CAPACITY = oal_pkg::DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IN_W    = ((CNT_W + 2 * oal_pkg::FIELD_W + 7) / 8) * 8,
    localparam int OUT_W   = ((CNT_W + 2 * oal_pkg::FIELD_W + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // position, entry_number, entry_name_ref, zero pad
    input  logic [IN_W-1:0]           s_axis_tdata,
    // cmd
    input  logic [oal_pkg::CMD_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_number, out_name_ref, fill_count, zero pad
    output logic [OUT_W-1:0]          m_axis_tdata,
    // ok
    output logic [0:0]                m_axis_tuser
);
    import oal_pkg::*;

    localparam int NUM_LO  = CNT_W;
    localparam int NAME_LO = CNT_W + FIELD_W;
    localparam int PAD_W   = OUT_W - CNT_W - 2 * FIELD_W;

    ctl_cmd_t           ctl;
    dp_status_t         status;
    logic               out_ok;
    logic [FIELD_W-1:0] out_number;
    logic [FIELD_W-1:0] out_name_ref;
    logic [CNT_W-1:0]   out_fill;

    // Command sequencer.
    oal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .ctl      (ctl)
    );

    // Storage, counters and result registers.
    oal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_cmd       (s_axis_tuser),
        .in_position  (s_axis_tdata[CNT_W-1:0]),
        .in_number    (s_axis_tdata[NUM_LO +: FIELD_W]),
        .in_name_ref  (s_axis_tdata[NAME_LO +: FIELD_W]),
        .ctl          (ctl),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_ok       (out_ok),
        .out_number   (out_number),
        .out_name_ref (out_name_ref),
        .out_fill     (out_fill)
    );

    // Pack the result word.
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_fill, out_name_ref, out_number};
    assign m_axis_tuser = out_ok;

endmodule

/* rtl/oal_checker.sv */
// ----------------------------------------------------------------------------
// Ordered array list port checker
// Concurrent assertions on the top-level ports, bound to every instance.
// ----------------------------------------------------------------------------
`include "ordered_array_list_macros.svh"

module oal_checker #(
    parameter int CAPACITY = oal_pkg::DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IN_W    = ((CNT_W + 2 * oal_pkg::FIELD_W + 7) / 8) * 8,
    localparam int OUT_W   = ((CNT_W + 2 * oal_pkg::FIELD_W + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_W-1:0]           s_axis_tdata,
    input  logic [oal_pkg::CMD_W-1:0] s_axis_tuser,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_W-1:0]          m_axis_tdata,
    input  logic [0:0]                m_axis_tuser
);
    import oal_pkg::*;

    localparam int FILL_LO = 2 * FIELD_W;

    // A stalled result word holds still.
    `OAL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result word changed while stalled")

    // A rejected command returns zero entry data.
    `OAL_ASSERT_NOW(a_reject_zero, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[FILL_LO-1:0] == '0, "rejected command returned entry data")

    // The reported fill count never exceeds the capacity.
    `OAL_ASSERT_NOW(a_fill_cap, m_axis_tvalid,
        m_axis_tdata[FILL_LO +: CNT_W] <= CNT_W'(CAPACITY), "fill count above capacity")

    // Commands are handled one at a time.
    `OAL_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "command word taken while another is in work")

endmodule

bind ordered_array_list oal_checker #(.CAPACITY(CAPACITY)) u_oal_checker (.*);
